@@ sv/rlbd_pkg.sv @@
`default_nettype none
package rlbd_pkg;

  localparam int unsigned BudgetWidth = 24;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rlbd_in_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] copies;
    logic       budget_exhausted;
  } rlbd_out_t;

  // one classified request from the parser to the budget stage
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic       emit;
    logic       last;
  } rlbd_run_t;

endpackage
`default_nettype wire

@@ sv/run_length_byte_decoder.sv @@
// run-length byte decoder, one compressed byte per request
//
// input queue side: present a byte on in_data with in_push high; it is taken
// at a clock edge where in_full is low. in_last marks the final byte of a
// stream; after it the parser returns to header and the budget reloads.
// result side: while out_empty is low, out_data holds the oldest decoded
// run (value, copies, budget_exhausted); raise out_pop to take it.
// cfg_we with cfg_wdata sets the output budget and reloads what is left;
// write it only while no request is in flight.
// a byte's request is registered in the middle queue, its result in the result queue.
// throughput: one byte per cycle while in_full is low; parser and budget
// stage are split by a small queue and results leave through a second
// queue, so each side stalls on its own. when out_pop stays low the result
// queue fills, then the middle queue, then in_full rises.
// reset: budget is zero, so no results come out until cfg_wdata is written;
// both queues are emptied and the parser waits for a header.
`default_nettype none
module run_length_byte_decoder #(
  parameter int unsigned MID_DEPTH = rlbd_pkg::QueueDepth,
  parameter int unsigned OUT_DEPTH = rlbd_pkg::QueueDepth
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  input  wire rlbd_pkg::rlbd_in_t               in_data,
  output logic                                  in_full,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output rlbd_pkg::rlbd_out_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [rlbd_pkg::BudgetWidth-1:0] cfg_wdata
);
  import rlbd_pkg::*;

  rlbd_run_t run_in, run_out;
  rlbd_out_t res;
  logic      run_push, run_full, run_pop, run_empty;
  logic      res_push, res_full;

  rlbd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .run_push (run_push),
    .run      (run_in),
    .run_full (run_full)
  );

  rlbd_fifo #(
    .WIDTH ($bits(rlbd_run_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (run_push),
    .wdata (run_in),
    .full  (run_full),
    .pop   (run_pop),
    .rdata (run_out),
    .empty (run_empty)
  );

  rlbd_budget u_budget (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .run_empty (run_empty),
    .run       (run_out),
    .run_pop   (run_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  rlbd_fifo #(
    .WIDTH ($bits(rlbd_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule
`default_nettype wire

@@ sv/rlbd_fifo.sv @@
`default_nettype none
module rlbd_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not grow on push");

  a_pop_only_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> count_r == $past(count_r) - CW'(1))
    else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

@@ sv/rlbd_parser.sv @@
`default_nettype none
module rlbd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire rlbd_pkg::rlbd_in_t  in_data,
  output logic                     in_full,
  output logic                     run_push,
  output rlbd_pkg::rlbd_run_t      run,
  input  wire logic                run_full
);
  import rlbd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  literal_left_r, literal_left_nxt;
  logic [6:0]  repeat_count_r, repeat_count_nxt;
  logic        accept;
  logic        emit;

  assign in_full = run_full;
  assign accept  = in_push & ~run_full;

  always_comb begin
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    repeat_count_nxt = repeat_count_r;
    emit             = 1'b0;
    run.value        = in_data.in_byte;
    run.count        = 8'd1;
    run.last         = in_data.in_last;
    case (phase_r)
      PH_REPEAT: begin
        emit      = 1'b1;
        run.count = {1'b0, repeat_count_r} + 8'd1;
        phase_nxt = PH_HEADER;
      end
      PH_LITERAL: begin
        emit             = 1'b1;
        literal_left_nxt = literal_left_r - 8'd1;
        if (literal_left_nxt == 8'd0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        if (in_data.in_byte[7]) begin
          // negative header: 1 - n literal bytes follow
          literal_left_nxt = 8'(9'd257 - {1'b0, in_data.in_byte});
          phase_nxt        = PH_LITERAL;
        end else begin
          repeat_count_nxt = in_data.in_byte[6:0];
          phase_nxt        = PH_REPEAT;
        end
      end
    endcase
    if (in_data.in_last) begin
      phase_nxt        = PH_HEADER;
      literal_left_nxt = 8'd0;
    end
    run.emit = emit;
    run_push = accept & (emit | in_data.in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      literal_left_r <= 8'd0;
      repeat_count_r <= 7'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      literal_left_r <= literal_left_nxt;
      repeat_count_r <= repeat_count_nxt;
    end
  end

  a_literal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LITERAL |-> literal_left_r != 8'd0)
    else $error("literal run with nothing left");

  a_repeat_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_REPEAT) |-> (run_push && run.count != 8'd0))
    else $error("repeat value not forwarded");

  a_header_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_HEADER) |-> !run.emit)
    else $error("header byte produced output");

endmodule
`default_nettype wire

@@ sv/rlbd_budget.sv @@
`default_nettype none
module rlbd_budget (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [rlbd_pkg::BudgetWidth-1:0]     cfg_wdata,
  input  wire logic                                 run_empty,
  input  wire rlbd_pkg::rlbd_run_t                  run,
  output logic                                      run_pop,
  output logic                                      res_push,
  output rlbd_pkg::rlbd_out_t                       res,
  input  wire logic                                 res_full
);
  import rlbd_pkg::*;

  logic [BudgetWidth-1:0] budget_r;
  logic [BudgetWidth-1:0] output_left_r, output_left_nxt;
  logic [BudgetWidth-1:0] left_after;
  logic [7:0]             clamped;
  logic                   produce;

  assign produce = run.emit & (output_left_r != '0);
  assign clamped = (output_left_r < BudgetWidth'(run.count)) ? output_left_r[7:0] : run.count;
  assign left_after = output_left_r - BudgetWidth'(clamped);

  assign run_pop  = ~run_empty & (~produce | ~res_full);
  assign res_push = run_pop & produce;

  assign res.value            = run.value;
  assign res.copies           = clamped;
  assign res.budget_exhausted = (left_after == '0);

  always_comb begin
    output_left_nxt = output_left_r;
    if (run_pop) begin
      if (run.last) begin
        output_left_nxt = budget_r;
      end else if (produce) begin
        output_left_nxt = left_after;
      end
    end
    if (cfg_we) begin
      output_left_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r      <= '0;
      output_left_r <= '0;
    end else begin
      output_left_r <= output_left_nxt;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

  a_copies_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res.copies != 8'd0)
    else $error("result with zero copies");

  a_exhaust_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.budget_exhausted && !run.last && !cfg_we) |=> output_left_r == '0)
    else $error("budget not used up after exhausting result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> BudgetWidth'(res.copies) <= output_left_r)
    else $error("result exceeds remaining budget");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import rlbd_pkg::*;

  localparam int unsigned MaxShown = 10;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles = 120;
  localparam logic [BudgetWidth-1:0] BudgetMax = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  rlbd_in_t in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  rlbd_out_t out_data;
  logic cfg_we = 1'b0;
  logic [BudgetWidth-1:0] cfg_wdata = '0;

  run_length_byte_decoder i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // decoder state as the predictor sees it
  logic [BudgetWidth-1:0] budget_reg = '0;
  logic [BudgetWidth-1:0] bytes_left = '0;
  phase_t parse_phase = PH_HEADER;
  logic [7:0] literal_left = '0;
  logic [7:0] repeat_n = '0;
  logic halted = 1'b0;
  rlbd_out_t pending_runs[$];
  int unsigned mismatches = 0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic hold_request = 1'b0;
  int unsigned hold_left = 0;
  logic [BudgetWidth-1:0] cur_budget = '0;

  function automatic void restart_parser();
    parse_phase = PH_HEADER;
    literal_left = '0;
    repeat_n = '0;
    bytes_left = budget_reg;
    halted = 1'b0;
  endfunction

  function automatic void load_budget(logic [BudgetWidth-1:0] v);
    budget_reg = v;
    bytes_left = v;
    halted = 1'b0;
  endfunction

  function automatic void decode_byte(rlbd_in_t req);
    logic [BudgetWidth-1:0] copies;
    logic emit;
    rlbd_out_t run;
    copies = '0;
    emit = 1'b0;
    case (parse_phase)
      PH_REPEAT: begin
        copies = repeat_n + 1'b1;
        emit = 1'b1;
        parse_phase = PH_HEADER;
      end
      PH_LITERAL: begin
        copies = 1;
        emit = 1'b1;
        literal_left = literal_left - 8'd1;
        if (literal_left == 8'd0) parse_phase = PH_HEADER;
      end
      default: begin
        if (req.in_byte[7]) begin
          literal_left = 8'(257 - int'(req.in_byte));
          parse_phase = PH_LITERAL;
        end else begin
          repeat_n = req.in_byte;
          parse_phase = PH_REPEAT;
        end
      end
    endcase
    if (emit && !halted && bytes_left != '0) begin
      if (copies > bytes_left) copies = bytes_left;
      bytes_left = bytes_left - copies;
      run.value = req.in_byte;
      run.copies = copies[7:0];
      run.budget_exhausted = (bytes_left == '0);
      if (bytes_left == '0) halted = 1'b1;
      pending_runs.push_back(run);
    end
    if (req.in_last) restart_parser();
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("%s", msg);
  endfunction

  function automatic void check_run(rlbd_out_t got);
    rlbd_out_t want;
    if (pending_runs.size() == 0) begin
      flag_mismatch($sformatf("unexpected run: value=%h copies=%0d exhausted=%b",
                              got.value, got.copies, got.budget_exhausted));
    end else begin
      want = pending_runs.pop_front();
      if (got.value !== want.value || got.copies !== want.copies ||
          got.budget_exhausted !== want.budget_exhausted)
        flag_mismatch($sformatf(
          {"run mismatch: exp value=%h copies=%0d exhausted=%b, ",
           "got value=%h copies=%0d exhausted=%b"},
          want.value, want.copies, want.budget_exhausted,
          got.value, got.copies, got.budget_exhausted));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      budget_reg = '0;
      restart_parser();
      pending_runs.delete();
    end else begin
      if (cfg_we) load_budget(cfg_wdata);
      if (in_push && !in_full) decode_byte(in_data);
      if (out_pop && !out_empty) check_run(out_data);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      out_pop = 1'b0;
      hold_left--;
    end else begin
      out_pop = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_data.in_byte = b;
    in_data.in_last = last;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_push = 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_budget(input logic [BudgetWidth-1:0] v);
    wait_idle();
    cfg_wdata = v;
    cfg_we = 1'b1;
    cur_budget = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [BudgetWidth-1:0] pick_budget();
    case ($urandom_range(7))
      0: return 1;
      1: return BudgetMax;
      2: return BudgetWidth'($urandom);
      3: return ($urandom_range(2) == 0) ? '0 : BudgetWidth'($urandom_range(2, 8));
      4, 5: return BudgetWidth'($urandom_range(2, 60));
      default: return BudgetWidth'($urandom_range(61, 1500));
    endcase
  endfunction

  // budget is zero out of reset: nothing decodes
  task automatic test_zero_budget();
    send_byte(8'h00, 1'b0);
    send_byte(8'hab, 1'b1);
    wait_idle();
  endtask

  task automatic test_run_kinds();
    write_budget(BudgetMax);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    // longest literal header, cut short by end of stream
    send_byte(8'h80, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    // header as the last byte
    send_byte(8'h05, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h33, 1'b1);
    wait_idle();
  endtask

  task automatic test_budget_clamp();
    write_budget(5);
    send_byte(8'h09, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    write_budget(1);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    wait_idle();
  endtask

  // budget write between header and value keeps the pending repeat
  task automatic test_budget_write_mid_run();
    write_budget(4);
    send_byte(8'h03, 1'b0);
    write_budget(2);
    send_byte(8'h77, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_streams(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned item_goal);
    logic [7:0] bytes_q[$];
    int unsigned sent;
    int unsigned len;
    int unsigned cut;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    write_budget(pick_budget());
    while (sent < item_goal) begin
      if ($urandom_range(2) == 0) write_budget(pick_budget());
      bytes_q.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 12)) bytes_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1) == 0) begin
            bytes_q.push_back(8'($urandom_range(127)));
            bytes_q.push_back(8'($urandom));
          end else begin
            len = ($urandom_range(29) == 0) ? $urandom_range(2, 129) : $urandom_range(2, 8);
            bytes_q.push_back(8'(257 - len));
            repeat (len) bytes_q.push_back(8'($urandom));
          end
        end
        if ($urandom_range(6) == 0) begin
          cut = $urandom_range(1, bytes_q.size());
          while (bytes_q.size() > cut) void'(bytes_q.pop_back());
        end
      end
      foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
      if (cur_budget != '0) sent += bytes_q.size();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_budget(BudgetMax);
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++)
      send_byte(i[0] ? 8'($urandom) : 8'($urandom_range(127)), i == 39);
    wait_idle();
  endtask

  initial begin
    src_idle_pct = 6;
    snk_idle_pct = 77;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_zero_budget();
    test_run_kinds();
    test_budget_clamp();
    test_budget_write_mid_run();
    test_random_streams(6, 77, 280);
    test_random_streams(77, 6, 280);
    test_random_streams(0, 0, 260);
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
